### src/slsl_pkg.sv
// Shared types, constants and helpers for the string literal span lexer.
package slsl_pkg;

  localparam int POS_BITS   = 24;
  localparam int FIELD_W    = 24;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    EV_LIT = 2'd0,
    EV_ERR = 2'd1,
    EV_END = 2'd2
  } event_t;

  typedef enum logic [2:0] {
    M_CODE   = 3'd0,
    M_SLASH  = 3'd1,
    M_LINE   = 3'd2,
    M_BLOCK  = 3'd3,
    M_BSTAR  = 3'd4,
    M_STRING = 3'd5,
    M_AFTER  = 3'd6
  } scan_mode_t;

  // One queue entry: an optional literal followed by an optional closing result.
  typedef struct packed {
    logic                has_lit;
    logic                has_tail;
    logic                tail_err;
    logic [POS_BITS-1:0] start;
    logic [POS_BITS-1:0] len;
  } entry_t;

  function automatic logic [FIELD_W-1:0] to_field(input logic [POS_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[FIELD_W-1:0];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

### src/string_literal_span_lexer_core.sv
// Top level of the string literal span lexer.
// Input channel: in_valid/in_ready carry one text byte per beat with end_of_text
// marking the final byte. Output channel: out_valid/out_ready carry result beats:
// a literal span (event_res 0), an unterminated string (1) or end of text (2);
// last is set on the final result of a text.
// Throughput: one text byte per cycle while the queue is not full. The lexer
// state machine updates in the cycle a byte is taken; a byte yields at most two
// results, which are packed in one entry of a four-entry queue and unpacked by
// the output register. With the queue empty, a result passes through the queue
// and then the output register before it is valid on the output; a second result
// from the same byte follows once the first has been accepted.
// in_ready falls only when the queue is full: with the receiver stalled, the
// output register holds one entry and the queue four more, so the input is held
// back once five result-bearing bytes are waiting; until then bytes pass freely.
// After an unterminated string the block takes bytes and discards them until reset.
// After a normal end result offsets restart at zero for the next text.
// Reset (rst, synchronous) empties the queue and output stage and returns the
// lexer to code mode at offset zero.
module string_literal_span_lexer_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   text_byte,
  input  logic                         end_of_text,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   event_res,
  output logic [slsl_pkg::FIELD_W-1:0] literal_start,
  output logic [slsl_pkg::FIELD_W-1:0] literal_length,
  output logic                         last
);
  import slsl_pkg::*;

  entry_t f_ent;
  entry_t q_ent;
  logic   f_push;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;
  logic   take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  slsl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .push        (f_push),
    .ent         (f_ent)
  );

  slsl_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (f_push),
    .wr_ent (f_ent),
    .full   (q_full),
    .pop    (q_pop),
    .rd_ent (q_ent),
    .empty  (q_empty)
  );

  slsl_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_ent          (q_ent),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_res      (event_res),
    .literal_start  (literal_start),
    .literal_length (literal_length),
    .last           (last)
  );

endmodule

### src/slsl_front.sv
// Front end: per-byte lexer state machine that builds result entries.
module slsl_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      text_byte,
  input  logic            end_of_text,
  output logic            push,
  output slsl_pkg::entry_t ent
);
  import slsl_pkg::*;

  scan_mode_t          mode, mode_next;
  logic                esc, esc_next;
  logic [POS_BITS-1:0] pos;
  logic [POS_BITS-1:0] open_q, open_next;
  logic [POS_BITS-1:0] close_q, close_next;
  logic                stopped;
  logic                lit_hit;
  logic                do_code;
  logic [POS_BITS:0]   diff;
  logic [POS_BITS:0]   span;
  logic [POS_BITS-1:0] span_len;

  // next state
  always_comb begin
    mode_next  = mode;
    esc_next   = esc;
    open_next  = open_q;
    close_next = close_q;
    lit_hit    = 1'b0;
    do_code    = 1'b0;
    case (mode)
      M_SLASH: begin
        if (text_byte == CH_SLASH) mode_next = M_LINE;
        else if (text_byte == CH_STAR) mode_next = M_BLOCK;
        else do_code = 1'b1;
      end
      M_LINE: begin
        if (text_byte == CH_LF) mode_next = M_CODE;
      end
      M_BLOCK: begin
        if (text_byte == CH_STAR) mode_next = M_BSTAR;
      end
      M_BSTAR: begin
        if (text_byte == CH_SLASH) mode_next = M_CODE;
        else if (text_byte != CH_STAR) mode_next = M_BLOCK;
      end
      M_STRING: begin
        if (text_byte == CH_BSL) begin
          esc_next = ~esc;
        end else if (text_byte == CH_QUOTE) begin
          if (esc) begin
            esc_next = 1'b0;
          end else begin
            close_next = pos;
            mode_next  = M_AFTER;
          end
        end else begin
          esc_next = 1'b0;
        end
      end
      M_AFTER: begin
        if (text_byte == CH_QUOTE) begin
          esc_next  = 1'b0;
          mode_next = M_STRING;
        end else if (!is_space(text_byte)) begin
          lit_hit = 1'b1;
          do_code = 1'b1;
        end
      end
      default: do_code = 1'b1;
    endcase
    // byte handled as code, possibly opening a string or a comment
    if (do_code) begin
      if (text_byte == CH_QUOTE) begin
        open_next = pos;
        esc_next  = 1'b0;
        mode_next = M_STRING;
      end else if (text_byte == CH_SLASH) begin
        mode_next = M_SLASH;
      end else begin
        mode_next = M_CODE;
      end
    end
  end

  // span length, clamped to the position range
  always_comb begin
    diff = {1'b0, close_next} - {1'b0, open_next};
    span = diff + {{POS_BITS{1'b0}}, 1'b1};
    if (close_next < open_next) span_len = '0;
    else if (span[POS_BITS]) span_len = POS_MAX;
    else span_len = span[POS_BITS-1:0];
  end

  // outputs
  always_comb begin
    ent.has_lit  = lit_hit || (end_of_text && (mode_next == M_AFTER));
    ent.has_tail = end_of_text;
    ent.tail_err = end_of_text && (mode_next == M_STRING);
    ent.start    = open_next;
    ent.len      = ent.has_lit ? span_len : '0;
    push         = take && !stopped && (ent.has_lit || ent.has_tail);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_CODE;
      esc     <= 1'b0;
      pos     <= '0;
      open_q  <= '0;
      close_q <= '0;
      stopped <= 1'b0;
    end else if (take && !stopped) begin
      if (end_of_text && (mode_next == M_STRING)) begin
        stopped <= 1'b1;
      end else if (end_of_text) begin
        mode    <= M_CODE;
        esc     <= 1'b0;
        pos     <= '0;
        open_q  <= '0;
        close_q <= '0;
      end else begin
        mode    <= mode_next;
        esc     <= esc_next;
        open_q  <= open_next;
        close_q <= close_next;
        if (pos != POS_MAX) pos <= pos + 1'b1;
      end
    end
  end

  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> (ent.has_lit || ent.has_tail))
    else $error("front pushed an entry with no result");

  a_stop_holds: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped && $stable(pos))
    else $error("lexer left the stopped state without reset");

endmodule

### src/slsl_fifo.sv
// Short entry queue between front and back ends.
module slsl_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  slsl_pkg::entry_t wr_ent,
  output logic             full,
  input  logic             pop,
  output slsl_pkg::entry_t rd_ent,
  output logic             empty
);
  import slsl_pkg::*;

  entry_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;

  assign full   = (count == FIFO_CW'(FIFO_DEPTH));
  assign empty  = (count == '0);
  assign rd_ent = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

### src/slsl_back.sv
// Back end: output register that unpacks each entry into one or two result beats.
module slsl_back (
  input  logic                         clk,
  input  logic                         rst,
  input  slsl_pkg::entry_t             q_ent,
  input  logic                         q_empty,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   event_res,
  output logic [slsl_pkg::FIELD_W-1:0] literal_start,
  output logic [slsl_pkg::FIELD_W-1:0] literal_length,
  output logic                         last
);
  import slsl_pkg::*;

  entry_t cur;
  logic   cur_valid;
  logic   beat;
  logic   done;

  assign beat  = cur_valid && out_ready;
  assign done  = beat && !(cur.has_lit && cur.has_tail);
  assign q_pop = !q_empty && (!cur_valid || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
    end else if (done) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_ent;
    else if (beat && cur.has_lit) cur.has_lit <= 1'b0;
  end

  always_comb begin
    out_valid = cur_valid;
    if (cur.has_lit) begin
      event_res      = EV_LIT;
      literal_start  = to_field(cur.start);
      literal_length = to_field(cur.len);
      last           = 1'b0;
    end else if (cur.tail_err) begin
      event_res      = EV_ERR;
      literal_start  = to_field(cur.start);
      literal_length = '0;
      last           = 1'b1;
    end else begin
      event_res      = EV_END;
      literal_start  = '0;
      literal_length = '0;
      last           = 1'b1;
    end
  end

  a_entry_nonempty: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.has_lit || cur.has_tail))
    else $error("empty entry held in output stage");

  a_lit_not_err: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && cur.has_lit && cur.has_tail) |-> !cur.tail_err)
    else $error("literal paired with unterminated error");

endmodule
